// File: hw/rtl/mpls_pkg.sv
// ----------------------------------------------------------------------------
// mpls_pkg
// Shared types and constants of the multiplexed PWM LED scanner: transaction
// payloads, channel geometry layout, register indexes and the byte mask.
// ----------------------------------------------------------------------------
package mpls_pkg;

    typedef struct packed {
        logic       cmd;
        logic [1:0] channel_sel;
        logic [2:0] column_sel;
        logic [2:0] row_sel;
        logic [7:0] level;
    } in_item_t;

    typedef struct packed {
        logic [31:0] output_word;
        logic [1:0]  out_channel;
        logic [2:0]  out_column;
        logic        last;
    } out_item_t;

    // channel geometry register: columns, rows, bit offset
    typedef struct packed {
        logic [3:0] cols;
        logic [3:0] rows;
        logic [4:0] offset;
    } geom_t;

    localparam int GEOM_REGS  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_CHANNELS = 3'd0,
        REG_COUNTER_TOP     = 3'd1,
        REG_WORD_BYTES      = 3'd2,
        REG_CHAN0_GEOM      = 3'd3,
        REG_CHAN1_GEOM      = 3'd4,
        REG_CHAN2_GEOM      = 3'd5,
        REG_CHAN3_GEOM      = 3'd6
    } cfg_reg_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        case (nbytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// File: hw/rtl/mpls_ram.sv
// ----------------------------------------------------------------------------
// mpls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/multiplexed_pwm_led_scanner_unit.sv
// A level write is stored when accepted; a tick advances the PWM counter, then checks each
// channel slot in turn and builds one word per column in a row loop that reads one stored
// level per cycle. One transaction at a time; ready again once the scan passes the last
// channel slot, and the word output can stall the scan. Reset (synchronous,
// active low) clears control state, the registers and the per-entry valid bits.
// ----------------------------------------------------------------------------
// multiplexed_pwm_led_scanner_unit
// PWM scanner for multiplexed LED matrices feeding a shift-register chain:
// stores brightness levels and emits one active-low word per channel column.
// ----------------------------------------------------------------------------
module multiplexed_pwm_led_scanner_unit #(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_COLUMNS  = 8,
    parameter int MAX_ROWS     = 8,
    parameter int LEVEL_BITS   = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mpls_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mpls_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mpls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import mpls_pkg::*;

    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CH_STRIDE   = MAX_COLUMNS * MAX_ROWS;
    localparam int NCH_MAX     = (MAX_CHANNELS < GEOM_REGS) ? MAX_CHANNELS : GEOM_REGS;
    localparam int CMP_W       = (LEVEL_BITS > 8) ? LEVEL_BITS : 8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CHAN = 4'b0010,
        S_ROW  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    // configuration registers
    logic [2:0] act_ch_reg;
    logic [7:0] cnt_top_reg;
    logic [2:0] word_bytes_reg;
    geom_t      geom_reg [GEOM_REGS];

    // sequencer and datapath
    state_t      state_reg, state_next;
    logic [2:0]  ch_reg, ch_next;
    logic [3:0]  col_reg, col_next;
    logic [3:0]  row_reg, row_next;
    logic [3:0]  rd_row_reg, rd_row_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [4:0]  offset_reg, offset_next;
    logic [3:0]  rows_reg, rows_next;
    logic [3:0]  cols_reg, cols_next;
    logic [31:0] word_reg, word_next;
    logic [7:0]  pwm_cnt_reg, pwm_cnt_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic [STORE_DEPTH-1:0] lvl_vld_reg;
    logic                   rd_vld_reg;

    logic [2:0]  nch;
    logic [3:0]  geom_cols [GEOM_REGS];
    logic [3:0]  cur_rows;
    logic [1:0]  last_ch;
    logic        s_accept;
    logic        wr_in_range;
    logic        wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [LEVEL_BITS-1:0] wr_level;
    logic [LEVEL_BITS-1:0] rd_level;
    logic [LEVEL_BITS-1:0] lv_eff;
    logic        lvl_hit;
    logic [5:0]  row_pos;
    logic [5:0]  col_pos;
    logic [31:0] word_out;
    logic        out_free;
    logic        word_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_ch_reg     <= '0;
            cnt_top_reg    <= 8'd255;
            word_bytes_reg <= 3'd4;
            for (int i = 0; i < GEOM_REGS; i++) begin
                geom_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_CHANNELS: act_ch_reg     <= cfg_data[2:0];
                REG_COUNTER_TOP:     cnt_top_reg    <= cfg_data[7:0];
                REG_WORD_BYTES:      word_bytes_reg <= cfg_data[2:0];
                REG_CHAN0_GEOM:      geom_reg[0]    <= geom_t'(cfg_data);
                REG_CHAN1_GEOM:      geom_reg[1]    <= geom_t'(cfg_data);
                REG_CHAN2_GEOM:      geom_reg[2]    <= geom_t'(cfg_data);
                REG_CHAN3_GEOM:      geom_reg[3]    <= geom_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // saturated channel count, column counts and the channel holding the final word
    always_comb begin
        nch = (act_ch_reg > 3'(NCH_MAX)) ? 3'(NCH_MAX) : act_ch_reg;
        last_ch = '0;
        for (int i = 0; i < GEOM_REGS; i++) begin
            geom_cols[i] = (geom_reg[i].cols > 4'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS)
                                                               : geom_reg[i].cols;
            if ((3'(i) < nch) && (geom_cols[i] != '0)) begin
                last_ch = 2'(i);
            end
        end
        cur_rows = (geom_reg[ch_reg[1:0]].rows > 4'(MAX_ROWS)) ? 4'(MAX_ROWS)
                                                              : geom_reg[ch_reg[1:0]].rows;
    end

    // level store write side
    assign wr_in_range = (32'(s_data.channel_sel) < 32'(MAX_CHANNELS)) &&
                         (32'(s_data.column_sel) < 32'(MAX_COLUMNS)) &&
                         (32'(s_data.row_sel) < 32'(MAX_ROWS));
    assign wr_en    = s_accept && (s_data.cmd == CMD_WRITE) && wr_in_range;
    assign wr_addr  = ADDR_W'(32'(s_data.channel_sel) * CH_STRIDE +
                              32'(s_data.column_sel) * MAX_ROWS + 32'(s_data.row_sel));
    assign wr_level = LEVEL_BITS'(s_data.level);

    // level store read side, one row per cycle
    assign rd_en   = (state_reg == S_ROW) && (row_reg < rows_reg);
    assign rd_addr = ADDR_W'(32'(ch_reg[1:0]) * CH_STRIDE + 32'(col_reg) * MAX_ROWS +
                             32'(row_reg));

    mpls_ram #(
        .WIDTH (LEVEL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_level_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_level),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_level)
    );

    // never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_vld_reg <= '0;
        end else if (wr_en) begin
            lvl_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_vld_reg <= lvl_vld_reg[rd_addr];
        end
    end

    // shared compare and bit-clear unit
    assign lv_eff   = rd_vld_reg ? rd_level : '0;
    assign lvl_hit  = CMP_W'(pwm_cnt_reg) > CMP_W'(lv_eff);
    assign row_pos  = 6'(offset_reg) + 6'(rd_row_reg);
    assign col_pos  = 6'(offset_reg) + 6'(rows_reg) + 6'(col_reg);
    assign word_out = (col_pos[5] ? word_reg : (word_reg & ~(32'd1 << col_pos[4:0]))) &
                      byte_mask(word_bytes_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign word_last = (ch_reg[1:0] == last_ch) && ((col_reg + 4'd1) == cols_reg);

    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        rd_row_next  = rd_row_reg;
        rd_pend_next = 1'b0;
        offset_next  = offset_reg;
        rows_next    = rows_reg;
        cols_next    = cols_reg;
        word_next    = word_reg;
        pwm_cnt_next = pwm_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (rd_pend_reg && lvl_hit && !row_pos[5]) begin
            word_next = word_reg & ~(32'd1 << row_pos[4:0]);
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_data.cmd == CMD_TICK)) begin
                    pwm_cnt_next = (pwm_cnt_reg >= cnt_top_reg) ? 8'd1 : pwm_cnt_reg + 8'd1;
                    ch_next      = '0;
                    state_next   = S_CHAN;
                end
            end
            S_CHAN: begin
                if (ch_reg >= nch) begin
                    state_next = S_IDLE;
                end else if (geom_cols[ch_reg[1:0]] == '0) begin
                    ch_next = ch_reg + 3'd1;
                end else begin
                    offset_next = geom_reg[ch_reg[1:0]].offset;
                    rows_next   = cur_rows;
                    cols_next   = geom_cols[ch_reg[1:0]];
                    col_next    = '0;
                    row_next    = '0;
                    word_next   = '1;
                    state_next  = S_ROW;
                end
            end
            S_ROW: begin
                if (rd_en) begin
                    row_next     = row_reg + 4'd1;
                    rd_row_next  = row_reg;
                    rd_pend_next = 1'b1;
                end else if (!rd_pend_reg) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.output_word = word_out;
                    m_data_next.out_channel = ch_reg[1:0];
                    m_data_next.out_column  = col_reg[2:0];
                    m_data_next.last        = word_last;
                    if ((col_reg + 4'd1) < cols_reg) begin
                        col_next   = col_reg + 4'd1;
                        row_next   = '0;
                        word_next  = '1;
                        state_next = S_ROW;
                    end else begin
                        ch_next    = ch_reg + 3'd1;
                        state_next = S_CHAN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            rd_pend_reg <= 1'b0;
            pwm_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            rd_pend_reg <= rd_pend_next;
            pwm_cnt_reg <= pwm_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        rd_row_reg <= rd_row_next;
        offset_reg <= offset_next;
        rows_reg   <= rows_next;
        cols_reg   <= cols_next;
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROW) |-> (row_reg <= rows_reg))
        else $error("row counter ran past the row count");

    a_pend_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == S_ROW))
        else $error("level read outstanding outside the row loop");

    a_tick_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_data.cmd == CMD_TICK)) |=> (pwm_cnt_reg != 8'd0))
        else $error("pwm counter zero after a tick");

    a_emit_column: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> ((col_reg < cols_reg) && (ch_reg < nch)))
        else $error("word emitted for a column or channel out of range");
`endif

endmodule
